>>> rtl/core/nwas_pkg.sv
// Package with shared types and constants for the NCO waveform address sequencer.
package nwas_pkg;

    // Field widths of the stream items and the configuration port.
    localparam int PHASE_W    = 16;
    localparam int COUNT_W    = 5;
    localparam int OFFSET_W   = 9;
    localparam int ACC_W      = 32;
    localparam int WRAP_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_UNIT   = 2'd2;

    // Configuration reset values.
    localparam logic [ACC_W-1:0]  ADVANCE_STEP_RST = 32'h0000_0000;
    localparam logic [WRAP_W-1:0] WRAP_LIMIT_RST   = 31'h7FFF_FFFF;
    localparam logic [ACC_W-1:0]  PHASE_UNIT_RST   = 32'h0000_0000;

    // Word offset bit swap: the sub-word advance moves up, the whole-word advance moves down.
    localparam logic [OFFSET_W-1:0] SUBWORD_MASK  = 9'h01F;
    localparam logic [OFFSET_W-1:0] WORD_MASK     = 9'h0E0;
    localparam int                  SUBWORD_SHIFT = 4;
    localparam int                  WORD_SHIFT    = 5;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_RUN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mult;
        logic emit;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/nwas_ctrl.sv
// Controller state machine that sequences one sample's run of word offsets.
module nwas_ctrl #(
    parameter int MAX_TRANSFERS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [nwas_pkg::COUNT_W-1:0] i_count,
    output logic                        o_in_ready,
    input  nwas_pkg::t_status           i_status,
    output nwas_pkg::t_cmd              o_cmd
);

    // Largest run length: limited by the parameter and by the 5-bit count field.
    localparam int LIMIT = ((MAX_TRANSFERS - 1) < 31) ? (MAX_TRANSFERS - 1) : 31;
    localparam int CNT_W = $clog2(LIMIT + 1);

    nwas_pkg::t_state r_state;
    nwas_pkg::t_state n_state;
    logic [CNT_W-1:0] r_remaining;
    logic [CNT_W-1:0] n_remaining;
    logic [nwas_pkg::COUNT_W-1:0] count_sat;

    // Saturate the requested count.
    assign count_sat = (i_count > nwas_pkg::COUNT_W'(LIMIT)) ? nwas_pkg::COUNT_W'(LIMIT)
                                                             : i_count;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nwas_pkg::ST_IDLE;
            r_remaining <= '0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            nwas_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_remaining   = CNT_W'(count_sat);
                    n_state       = nwas_pkg::ST_MULT;
                end
            end
            nwas_pkg::ST_MULT: begin
                o_cmd.mult = 1'b1;
                if (r_remaining == '0) begin
                    n_state = nwas_pkg::ST_IDLE;
                end else begin
                    n_state = nwas_pkg::ST_RUN;
                end
            end
            nwas_pkg::ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.last  = (r_remaining == CNT_W'(1));
                    n_remaining = r_remaining - CNT_W'(1);
                    if (r_remaining == CNT_W'(1)) begin
                        n_state = nwas_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = nwas_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/nwas_datapath.sv
// Datapath with configuration registers, phase product, accumulator and output register.
module nwas_datapath #(
    parameter int FRAC_W = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [nwas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nwas_pkg::ACC_W-1:0]      i_cfg_data,
    input  logic [nwas_pkg::PHASE_W-1:0]    i_phase,
    input  nwas_pkg::t_cmd                  i_cmd,
    output nwas_pkg::t_status               o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [nwas_pkg::OFFSET_W-1:0]   o_word_offset,
    output logic                            o_last
);

    logic [nwas_pkg::ACC_W-1:0]   r_advance_step;
    logic [nwas_pkg::WRAP_W-1:0]  r_wrap_limit;
    logic [nwas_pkg::ACC_W-1:0]   r_phase_unit;
    logic [nwas_pkg::ACC_W-1:0]   r_accumulator;
    logic [nwas_pkg::PHASE_W-1:0] r_phase;
    logic [nwas_pkg::ACC_W-1:0]   r_modulation;
    logic                         r_out_valid;
    logic [nwas_pkg::OFFSET_W-1:0] r_word_offset;
    logic                         r_last;

    logic [nwas_pkg::ACC_W-1:0]   wrap_ext;
    logic [nwas_pkg::ACC_W-1:0]   phase_ext;
    logic [nwas_pkg::ACC_W-1:0]   mod_sum;
    logic [nwas_pkg::ACC_W-1:0]   mod_fold;
    logic [nwas_pkg::ACC_W-1:0]   idx_full;
    logic [nwas_pkg::OFFSET_W-1:0] idx9;
    logic [nwas_pkg::OFFSET_W-1:0] word_offset;
    logic [nwas_pkg::ACC_W-1:0]   acc_sum;
    logic [nwas_pkg::ACC_W-1:0]   acc_next;
    logic                         out_free;

    assign wrap_ext  = {1'b0, r_wrap_limit};
    assign phase_ext = {{(nwas_pkg::ACC_W - nwas_pkg::PHASE_W){r_phase[nwas_pkg::PHASE_W-1]}},
                        r_phase};

    // Modulated phase, folded once into the waveform period.
    always_comb begin
        mod_sum = r_accumulator + r_modulation;
        if (mod_sum[nwas_pkg::ACC_W-1]) begin
            mod_fold = mod_sum + wrap_ext;
        end else if (mod_sum > wrap_ext) begin
            mod_fold = mod_sum - wrap_ext;
        end else begin
            mod_fold = mod_sum;
        end
    end

    // Integer part with sign fill, then swap sub-word and whole-word bits.
    assign idx_full    = $unsigned($signed(mod_fold) >>> FRAC_W);
    assign idx9        = {1'b0, idx_full[7:0]};
    assign word_offset = ((idx9 & nwas_pkg::SUBWORD_MASK) << nwas_pkg::SUBWORD_SHIFT) |
                         ((idx9 & nwas_pkg::WORD_MASK) >> nwas_pkg::WORD_SHIFT);

    // Accumulator advance with a single wrap.
    always_comb begin
        acc_sum = r_accumulator + r_advance_step;
        if (acc_sum > wrap_ext) begin
            acc_next = acc_sum - wrap_ext;
        end else begin
            acc_next = acc_sum;
        end
    end

    assign out_free          = !r_out_valid || i_out_ready;
    assign o_status.out_free = out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_advance_step <= nwas_pkg::ADVANCE_STEP_RST;
            r_wrap_limit   <= nwas_pkg::WRAP_LIMIT_RST;
            r_phase_unit   <= nwas_pkg::PHASE_UNIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nwas_pkg::CFG_ADVANCE_STEP: r_advance_step <= i_cfg_data;
                nwas_pkg::CFG_WRAP_LIMIT:   r_wrap_limit   <= i_cfg_data[nwas_pkg::WRAP_W-1:0];
                nwas_pkg::CFG_PHASE_UNIT:   r_phase_unit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sample capture and phase product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_phase <= i_phase;
        end
        if (i_cmd.mult) begin
            r_modulation <= r_phase_unit * phase_ext;
        end
    end

    // Accumulator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accumulator <= '0;
        end else if (i_cmd.emit) begin
            r_accumulator <= acc_next;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_word_offset <= word_offset;
            r_last        <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_offset = r_word_offset;
    assign o_last        = r_last;

endmodule

>>> rtl/core/nco_waveform_address_sequencer.sv
// Top level of the NCO waveform address sequencer.
// Each input item is one audio sample carrying a signed phase offset and a transfer count;
// the block answers with that many waveform buffer word offsets, the final one flagged on
// tlast, and keeps an 8.24 phase accumulator between samples. A sample is accepted in the
// idle state, its phase product is formed in the multiplier state, and the run state then
// gives one offset per cycle from the single accumulator add-and-wrap loop, slowed only
// when the output register is held by back pressure. A count of zero emits nothing and
// leaves the accumulator alone; counts above MAX_TRANSFERS - 1 are clipped. Configuration
// writes are always accepted and must only be made while the block is idle.
module nco_waveform_address_sequencer #(
    parameter int FRAC_W        = 24,
    parameter int MAX_TRANSFERS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nwas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nwas_pkg::ACC_W-1:0]        i_cfg_data,
    // Sample input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [nwas_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] phase_offset, [20:16] transfer_count
    // Word offset output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [nwas_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [8:0] word_offset
    output logic                              m_axis_tlast   // last_transfer
);

    nwas_pkg::t_cmd    cmd;
    nwas_pkg::t_status status;
    logic [nwas_pkg::OFFSET_W-1:0] word_offset;
    logic [nwas_pkg::PHASE_W-1:0]  phase_offset;
    logic [nwas_pkg::COUNT_W-1:0]  transfer_count;

    assign o_cfg_ready    = 1'b1;
    assign phase_offset   = s_axis_tdata[15:0];
    assign transfer_count = s_axis_tdata[20:16];

    // Sequencing control.
    nwas_ctrl #(
        .MAX_TRANSFERS (MAX_TRANSFERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_count    (transfer_count),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    nwas_datapath #(
        .FRAC_W (FRAC_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_phase       (phase_offset),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_word_offset (word_offset),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {{(nwas_pkg::OUT_DATA_W - nwas_pkg::OFFSET_W){1'b0}}, word_offset};

endmodule
